// ===== hw/rtl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: widths, codes, cell types.
// No dependencies.
package ffha_pkg;
  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned IdxBits   = $clog2(MaxBlocks);
  localparam int unsigned CntBits   = IdxBits + 1;
  localparam int unsigned AddrBits  = 20;
  localparam int unsigned SizeBits  = 21;

  localparam logic [1:0] RcOk       = 2'd0;
  localparam logic [1:0] RcNoHeap   = 2'd1;
  localparam logic [1:0] RcFull     = 2'd2;
  localparam logic [1:0] RcBadFree  = 2'd3;

  localparam logic [1:0] CfgHeader  = 2'd0;
  localparam logic [1:0] CfgChunk   = 2'd1;
  localparam logic [1:0] CfgLimit   = 2'd2;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [SizeBits-1:0] size;
    logic                used;
  } blk_t;

  // Operation broadcast to all cells
  localparam logic [2:0] OpHold   = 3'd0;
  localparam logic [2:0] OpShUp   = 3'd1; // cell idx takes wdata, cells above take lower neighbour
  localparam logic [2:0] OpShDn   = 3'd2; // cell idx takes wdata, cells above take upper neighbour
  localparam logic [2:0] OpWrite  = 3'd3; // cell idx takes wdata

  typedef struct packed {
    logic [2:0]          op;
    logic [IdxBits-1:0]  idx;
    blk_t                wdata;
  } cell_ctl_t;
endpackage

// ===== hw/rtl/ffha_cell.sv =====
// One table entry of the heap allocator; shifts with its neighbours.
// Depends on ffha_pkg.
module ffha_cell import ffha_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IdxBits-1:0] my_idx_i,
  input  cell_ctl_t          ctl_i,
  input  blk_t               lower_i,
  input  blk_t               upper_i,
  output blk_t               blk_o
);
  logic [AddrBits-1:0] start_q;
  logic [SizeBits-1:0] size_q;
  logic                used_q;
  blk_t blk_q, blk_d;

  assign blk_q = '{start: start_q, size: size_q, used: used_q};

  always_comb begin
    blk_d = blk_q;
    unique case (ctl_i.op)
      OpShUp: begin
        if (my_idx_i > ctl_i.idx) blk_d = lower_i;
        else if (my_idx_i == ctl_i.idx) blk_d = ctl_i.wdata;
      end
      OpShDn: begin
        if (my_idx_i > ctl_i.idx) blk_d = upper_i;
        else if (my_idx_i == ctl_i.idx) blk_d = ctl_i.wdata;
      end
      OpWrite: if (my_idx_i == ctl_i.idx) blk_d = ctl_i.wdata;
      default: blk_d = blk_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= blk_d.used;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= blk_d.start;
    size_q  <= blk_d.size;
  end

  assign blk_o = blk_q;
endmodule

// ===== hw/rtl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator: control sequencer and cell row.
// Depends on ffha_pkg and ffha_cell.
// Allocate searches, grows the heap when no block fits, takes the block and splits off a
// large remainder; free searches and merges up, then down. busy is high from accept until
// done_o; the next item can be taken in the done_o cycle, not before. No output stall.
// Reset clears used marks, count, heap top and loads register defaults.
module first_fit_heap_allocator_top import ffha_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [20:0]         cfg_data_i,
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic [SizeBits-1:0] req_bytes_i,
  input  logic [AddrBits-1:0] free_addr_i,
  output logic                done_o,
  output logic [AddrBits-1:0] payload_addr_o,
  output logic [1:0]          result_code_o
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSrch  = 4'd1;
  localparam logic [3:0] StGrow  = 4'd2;
  localparam logic [3:0] StTake  = 4'd3;
  localparam logic [3:0] StSplit = 4'd4;
  localparam logic [3:0] StFSrch = 4'd5;
  localparam logic [3:0] StMrgU  = 4'd6;
  localparam logic [3:0] StMrgL  = 4'd7;
  localparam logic [3:0] StDone  = 4'd8;

  logic [7:0]           hdr_q;
  logic [SizeBits-1:0]  chunk_q, limit_q;
  logic [3:0]           st_q, st_d;
  logic [SizeBits-1:0]  req_q;
  logic [AddrBits-1:0]  faddr_q;
  logic [IdxBits-1:0]   idx_q, idx_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [SizeBits-1:0]  top_q, top_d;
  logic [AddrBits-1:0]  pa_q, pa_d;
  logic [1:0]           rc_q, rc_d;
  logic                 done_q, done_d;
  cell_ctl_t            ctl;
  blk_t                 blks [MaxBlocks];

  for (genvar g = 0; g < MaxBlocks; g++) begin : g_cell
    blk_t lo, hi;
    if (g == 0) begin : g_lo0
      assign lo = blks[0];
    end else begin : g_lo
      assign lo = blks[g-1];
    end
    if (g == MaxBlocks-1) begin : g_hiN
      assign hi = blks[g];
    end else begin : g_hi
      assign hi = blks[g+1];
    end
    ffha_cell u_cell (
      .clk_i, .rst_ni,
      .my_idx_i(IdxBits'(g)),
      .ctl_i(ctl),
      .lower_i(lo),
      .upper_i(hi),
      .blk_o(blks[g])
    );
  end

  // Per-cell match vectors
  logic [MaxBlocks-1:0] fit_v, addr_v;
  always_comb begin
    for (int k = 0; k < MaxBlocks; k++) begin
      fit_v[k]  = (CntBits'(k) < cnt_q) && !blks[k].used && (blks[k].size >= req_q);
      addr_v[k] = (CntBits'(k) < cnt_q) &&
                  (AddrBits'(blks[k].start + AddrBits'(hdr_q)) == faddr_q);
    end
  end

  logic               fit_hit, addr_hit;
  logic [IdxBits-1:0] fit_idx, addr_idx;
  always_comb begin
    fit_hit = 1'b0; fit_idx = '0; addr_hit = 1'b0; addr_idx = '0;
    for (int k = MaxBlocks-1; k >= 0; k--) begin
      if (fit_v[k]) begin fit_hit = 1'b1; fit_idx = IdxBits'(k); end
      if (addr_v[k]) begin addr_hit = 1'b1; addr_idx = IdxBits'(k); end
    end
  end

  blk_t cur, nxt, prv;
  assign cur = blks[idx_q];
  assign nxt = blks[IdxBits'(idx_q + 1'b1)];
  assign prv = blks[IdxBits'(idx_q - 1'b1)];

  logic [SizeBits:0]   need, grow, lim;
  logic [SizeBits:0]   left;
  logic                full;
  assign need = {1'b0, req_q} + (SizeBits+1)'(hdr_q);
  assign grow = ({1'b0, chunk_q} < need) ? need : {1'b0, chunk_q};
  assign lim  = (limit_q > SizeBits'(21'h100000)) ? (SizeBits+1)'(21'h100000)
                                                  : {1'b0, limit_q};
  assign left = {1'b0, cur.size} - {1'b0, req_q};
  assign full = (cnt_q == CntBits'(MaxBlocks));

  always_comb begin
    st_d = st_q; idx_d = idx_q; cnt_d = cnt_q; top_d = top_q;
    pa_d = pa_q; rc_d = rc_q; done_d = 1'b0;
    ctl = '{op: OpHold, idx: idx_q, wdata: cur};
    unique case (st_q)
      StIdle: if (start) st_d = (cmd_i == CmdFree) ? StFSrch : StSrch;
      StSrch: begin
        pa_d = '0;
        if (fit_hit) begin
          idx_d = fit_idx; st_d = StTake;
        end else st_d = StGrow;
      end
      StGrow: begin
        if ({1'b0, top_q} >= lim || {1'b0, top_q} + grow > lim) begin
          rc_d = RcNoHeap; st_d = StDone;
        end else if (full) begin
          rc_d = RcFull; st_d = StDone;
        end else begin
          ctl.op = OpWrite;
          ctl.idx = IdxBits'(cnt_q);
          ctl.wdata = '{start: AddrBits'(top_q),
                        size: SizeBits'(grow - (SizeBits+1)'(hdr_q)), used: 1'b0};
          idx_d = IdxBits'(cnt_q);
          cnt_d = cnt_q + 1'b1;
          top_d = SizeBits'({1'b0, top_q} + grow);
          st_d = StTake;
        end
      end
      StTake: begin
        rc_d = RcOk;
        pa_d = AddrBits'(cur.start + AddrBits'(hdr_q));
        if (left > (SizeBits+1)'(hdr_q) && !full) begin
          ctl.op = OpShUp;
          ctl.wdata = '{start: cur.start, size: req_q, used: 1'b1};
          st_d = StSplit;
        end else begin
          ctl.op = OpWrite;
          ctl.wdata = '{start: cur.start, size: cur.size, used: 1'b1};
          st_d = StDone;
        end
      end
      StSplit: begin
        // cell idx+1 holds the old copy of cell idx
        ctl.op = OpWrite;
        ctl.idx = IdxBits'(idx_q + 1'b1);
        ctl.wdata = '{start: AddrBits'(nxt.start + AddrBits'(hdr_q) + AddrBits'(req_q)),
                      size: SizeBits'({1'b0, nxt.size} - {1'b0, req_q} -
                                      (SizeBits+1)'(hdr_q)),
                      used: 1'b0};
        cnt_d = cnt_q + 1'b1;
        st_d = StDone;
      end
      StFSrch: begin
        pa_d = '0;
        if (faddr_q == '0 || !addr_hit || !blks[addr_idx].used) begin
          rc_d = RcBadFree; st_d = StDone;
        end else begin
          rc_d = RcOk;
          idx_d = addr_idx;
          ctl.op = OpWrite; ctl.idx = addr_idx;
          ctl.wdata = '{start: blks[addr_idx].start, size: blks[addr_idx].size,
                        used: 1'b0};
          st_d = StMrgU;
        end
      end
      StMrgU: begin
        // absorb the upper neighbour and close the gap above
        if (CntBits'(idx_q) + 1'b1 < cnt_q && !nxt.used) begin
          ctl.op = OpShDn;
          ctl.wdata = '{start: cur.start,
                        size: SizeBits'(cur.size + nxt.size + SizeBits'(hdr_q)),
                        used: 1'b0};
          cnt_d = cnt_q - 1'b1;
        end
        st_d = StMrgL;
      end
      StMrgL: begin
        // lower neighbour absorbs this block
        if (idx_q != '0 && !prv.used) begin
          ctl.op = OpShDn;
          ctl.idx = IdxBits'(idx_q - 1'b1);
          ctl.wdata = '{start: prv.start,
                        size: SizeBits'(prv.size + cur.size + SizeBits'(hdr_q)),
                        used: 1'b0};
          cnt_d = cnt_q - 1'b1;
        end
        st_d = StDone;
      end
      StDone: begin
        done_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= 8'd32; chunk_q <= SizeBits'(1024); limit_q <= SizeBits'(21'h100000);
      st_q <= StIdle; cnt_q <= '0; top_q <= '0; done_q <= 1'b0;
      rc_q <= RcOk; pa_q <= '0; idx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgHeader: hdr_q <= cfg_data_i[7:0];
          CfgChunk:  chunk_q <= cfg_data_i;
          CfgLimit:  limit_q <= cfg_data_i;
          default:   ;
        endcase
      end
      st_q <= st_d; cnt_q <= cnt_d; top_q <= top_d; done_q <= done_d;
      rc_q <= rc_d; pa_q <= pa_d; idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && start) begin
      req_q <= req_bytes_i; faddr_q <= free_addr_i;
    end
  end

  assign busy = (st_q != StIdle);
  assign done_o = done_q;
  assign payload_addr_o = pa_q;
  assign result_code_o = rc_q;
endmodule

// ===== bench/first_fit_heap_allocator_top_tb.sv =====
// Testbench for first_fit_heap_allocator_top: table-based predictor in a small
// scoreboard class, directed and random allocate/free items over several configs.
// Depends on ffha_pkg and the allocator RTL.
`timescale 1ns / 100ps

module first_fit_heap_allocator_top_tb;
  import ffha_pkg::*;

  localparam longint unsigned M20 = 64'hFFFFF;
  localparam longint unsigned M21 = 64'h1FFFFF;

  typedef struct {
    logic [AddrBits-1:0] paddr;
    logic [1:0]          code;
  } grant_t;

  class heap_scoreboard;
    longint unsigned hdr, chunk, limit, top;
    longint unsigned st[MaxBlocks];
    longint unsigned sz[MaxBlocks];
    bit              us[MaxBlocks];
    int              cnt;
    int              errors;
    grant_t          pending_grants[$];

    function new();
      hdr = 32; chunk = 1024; limit = 1048576; top = 0; cnt = 0; errors = 0;
      foreach (us[k]) us[k] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, longint unsigned val);
      if (idx == CfgHeader) hdr = val & 64'hFF;
      else if (idx == CfgChunk) chunk = val & M21;
      else if (idx == CfgLimit) limit = val & M21;
    endfunction

    function void drop_entry(int i);
      for (int k = i; k + 1 < cnt; k++) begin
        st[k] = st[k+1]; sz[k] = sz[k+1]; us[k] = us[k+1];
      end
      cnt--;
    endfunction

    // payload address of a random block with the given used mark, zero if none
    function logic [AddrBits-1:0] pick_addr(bit want_used);
      int idx[$];
      for (int k = 0; k < cnt; k++) if (us[k] == want_used) idx.push_back(k);
      if (idx.size() == 0) return '0;
      return AddrBits'((st[idx[$urandom_range(idx.size()-1)]] + hdr) & M20);
    endfunction

    function void note_item(logic cmd, logic [SizeBits-1:0] req, logic [AddrBits-1:0] fa);
      longint unsigned need, grow, lim, left;
      int i;
      bit found;
      grant_t g;
      g.paddr = '0;
      g.code  = RcOk;
      found   = 1'b0;
      if (cmd == CmdAlloc) begin
        for (i = 0; i < cnt; i++)
          if (!us[i] && sz[i] >= req) begin
            found = 1'b1;
            break;
          end
        if (!found) begin
          need = req + hdr;
          grow = (chunk < need) ? need : chunk;
          lim  = (limit > 64'h100000) ? 64'h100000 : limit;
          if (top >= lim || top + grow > lim) g.code = RcNoHeap;
          else if (cnt >= MaxBlocks) g.code = RcFull;
          else begin
            i = cnt;
            st[i] = top & M20;
            sz[i] = (grow - hdr) & M21;
            us[i] = 1'b0;
            cnt++;
            top = (top + grow) & M21;
            found = 1'b1;
          end
        end
        if (found) begin
          left = sz[i] - req;
          if (left > hdr && cnt < MaxBlocks) begin
            for (int k = cnt; k > i + 1; k--) begin
              st[k] = st[k-1]; sz[k] = sz[k-1]; us[k] = us[k-1];
            end
            st[i+1] = (st[i] + hdr + req) & M20;
            sz[i+1] = (left - hdr) & M21;
            us[i+1] = 1'b0;
            sz[i] = req;
            cnt++;
          end
          us[i] = 1'b1;
          g.paddr = AddrBits'((st[i] + hdr) & M20);
        end
      end else begin
        if (fa != 0)
          for (i = 0; i < cnt; i++)
            if (((st[i] + hdr) & M20) == fa) begin
              found = 1'b1;
              break;
            end
        if (!found || !us[i]) g.code = RcBadFree;
        else begin
          us[i] = 1'b0;
          while (i + 1 < cnt && !us[i+1]) begin
            sz[i] = (sz[i] + sz[i+1] + hdr) & M21;
            drop_entry(i + 1);
          end
          while (i > 0 && !us[i-1]) begin
            sz[i-1] = (sz[i-1] + sz[i] + hdr) & M21;
            drop_entry(i);
            i--;
          end
        end
      end
      pending_grants.push_back(g);
    endfunction

    function void check_result(logic [AddrBits-1:0] paddr, logic [1:0] code);
      grant_t g;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result addr %h code %0d", $time, paddr, code);
        errors++;
        return;
      end
      g = pending_grants.pop_front();
      if (paddr !== g.paddr) begin
        $display("%0t: payload_addr expected %h actual %h", $time, g.paddr, paddr);
        errors++;
      end
      if (code !== g.code) begin
        $display("%0t: result_code expected %0d actual %0d", $time, g.code, code);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [20:0]         cfg_data_i = '0;
  logic                start = 1'b0;
  logic                busy;
  logic                cmd_i = 1'b0;
  logic [SizeBits-1:0] req_bytes_i = '0;
  logic [AddrBits-1:0] free_addr_i = '0;
  logic                done_o;
  logic [AddrBits-1:0] payload_addr_o;
  logic [1:0]          result_code_o;

  heap_scoreboard sb = new();
  bit quiet = 1'b0;

  first_fit_heap_allocator_top uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i)
    if (rst_ni && done_o) sb.check_result(payload_addr_o, result_code_o);

  task automatic send_item(logic cmd, logic [SizeBits-1:0] req, logic [AddrBits-1:0] fa);
    bit acc;
    @(posedge clk_i);
    start <= 1'b1;
    cmd_i <= cmd;
    req_bytes_i <= req;
    free_addr_i <= fa;
    do begin
      @(negedge clk_i);
      acc = !busy;
      @(posedge clk_i);
    end while (!acc);
    sb.note_item(cmd, req, fa);
    if (!quiet && $urandom_range(99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(4)) @(posedge clk_i);
    end else begin
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    while (sb.pending_grants.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [20:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic alloc(int unsigned req);
    send_item(CmdAlloc, SizeBits'(req), AddrBits'($urandom));
  endtask

  task automatic release_addr(int unsigned fa);
    send_item(CmdFree, SizeBits'($urandom), AddrBits'(fa));
  endtask

  task automatic random_items(int n, int max_req);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 50) begin
        if ($urandom_range(19) == 0) alloc($urandom_range(1048576));
        else alloc($urandom_range(max_req));
      end else if (r < 85) release_addr(sb.pick_addr(1'b1));
      else if (r < 91) release_addr(sb.pick_addr(1'b0));
      else if (r < 94) release_addr('0);
      else release_addr($urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // default registers: extremes, growth, split, merges, bad frees
    alloc(0);
    alloc(1);
    alloc(21'd1048576);
    alloc(100);
    alloc(2000);
    release_addr(sb.pick_addr(1'b1));
    release_addr(sb.pick_addr(1'b0));
    release_addr('0);
    release_addr(20'hFFFFF);
    alloc(50);
    release_addr(sb.pick_addr(1'b1));
    release_addr(sb.pick_addr(1'b1));
    release_addr(sb.pick_addr(1'b1));
    random_items(40, 300);
    quiet = 1'b1;
    random_items(60, 300);
    quiet = 1'b0;
    random_items(50, 3000);
    drain();

    // no header, exact-size growth: fills the table
    write_reg(CfgHeader, 21'd0);
    write_reg(CfgChunk, 21'd1);
    for (int k = 0; k < 70; k++) alloc($urandom_range(1, 8));
    random_items(60, 16);
    drain();

    // widest header, largest chunk
    write_reg(CfgHeader, 21'd255);
    write_reg(CfgChunk, 21'd1048576);
    write_reg(CfgLimit, 21'd1048576);
    random_items(50, 400);
    drain();

    // zero limit: all growth refused
    write_reg(CfgLimit, 21'd0);
    random_items(40, 400);
    drain();

    // tight limit just above the heap top
    write_reg(CfgHeader, 21'd1);
    write_reg(CfgChunk, 21'd64);
    write_reg(CfgLimit, 21'(sb.top + 3000));
    random_items(90, 200);
    drain();

    if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== first_fit_heap_allocator_top.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_cell.sv
hw/rtl/first_fit_heap_allocator_top.sv
bench/first_fit_heap_allocator_top_tb.sv
